@@ hw/rtl/ssw_pkg.sv @@
// Shared types, widths and constants of the skid steer wheel rpm block.
package ssw_pkg;

  // Field and register widths
  localparam int IN_W      = 16;
  localparam int OUT_W     = 16;
  localparam int SCALE_W   = 11;
  localparam int LIM_W     = 15;
  localparam int TRACK_W   = 12;
  localparam int RPM_W     = 15;
  localparam int GEAR_W    = 10;
  localparam int CIRC_W    = 13;
  localparam int CFG_W     = 15;
  localparam int CFG_IDX_W = 3;

  // Datapath widths
  localparam int PV_W    = IN_W + SCALE_W + 1;   // scaled command product
  localparam int P_W     = 27;                   // 2000 * vx
  localparam int TURN_W  = IN_W + TRACK_W;       // track * w
  localparam int WHEEL_W = 29;                   // signed wheel speed
  localparam int MAG_W   = WHEEL_W - 1;          // wheel speed magnitude
  localparam int K_W     = 15;                   // numerator factor
  localparam int Q_W     = 15;                   // quotient magnitude bits
  localparam int NUM_W   = MAG_W + K_W;          // divider dividend
  localparam int CL_W    = CIRC_W + RPM_W;       // circumference * rpm limit

  localparam int FRAC_BITS_DEF = 10;
  localparam int SCALE_SHIFT   = 10;
  localparam int TRACK_DIV     = 2000;
  localparam int KIN_STAGES    = 8;

  localparam logic [SCALE_W-1:0] SCALE_ONE = 11'd1024;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAFE_MODE,
    REG_SAFE_SCALE,
    REG_LINEAR_LIMIT,
    REG_ANGULAR_LIMIT,
    REG_TRACK_MM,
    REG_MOTOR_RPM_LIMIT,
    REG_GEAR_RATIO,
    REG_CIRCUMFERENCE_MM
  } ssw_reg_e;

  // Effective configuration seen by the datapath
  typedef struct packed {
    logic               safe_mode;
    logic [SCALE_W-1:0] safe_scale;
    logic [LIM_W-1:0]   linear_limit;
    logic [LIM_W-1:0]   angular_limit;
    logic [TRACK_W-1:0] track_mm;
    logic [RPM_W-1:0]   rpm_limit;
    logic [GEAR_W-1:0]  gear_ratio;
    logic [CIRC_W-1:0]  circumference_mm;
  } ssw_cfg_t;

  // Control that travels with an item along the divider chain
  typedef struct packed {
    logic valid;
    logic neg_r;
    logic neg_l;
  } ssw_ctl_t;

  function automatic int max_int(int a, int b);
    return (a > b) ? a : b;
  endfunction

endpackage

@@ hw/rtl/skid_steer_wheel_rpm.sv @@
// Top level: configuration registers, front pipeline, divider cell chain, output.
// The path from an accepted start to done_o runs through 8 front stages, one
// divider cell per quotient bit for 15 bits, and one output register.
// Throughput: one item per cycle; busy stays low and the receiver cannot stall.
// Reset clears all item valids and loads the register defaults; there is no
// clearing pass.
module skid_steer_wheel_rpm #(
  parameter int FRAC_BITS = ssw_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [ssw_pkg::IN_W-1:0]     linear_speed_i,
  input  logic signed [ssw_pkg::IN_W-1:0]     yaw_rate_i,
  input  logic                                cfg_we_i,
  input  logic [ssw_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [ssw_pkg::CFG_W-1:0]           cfg_wdata_i,
  output logic                                done_o,
  output logic signed [ssw_pkg::OUT_W-1:0]    right_motor_rpm_o,
  output logic signed [ssw_pkg::OUT_W-1:0]    left_motor_rpm_o
);
  import ssw_pkg::*;

  localparam int DivW    = max_int(MAG_W, CIRC_W + FRAC_BITS);
  localparam int LATENCY = KIN_STAGES + Q_W + 1;

  logic               safe_mode_q;
  logic [SCALE_W-1:0] safe_scale_q;
  logic [LIM_W-1:0]   linear_limit_q, angular_limit_q;
  logic [TRACK_W-1:0] track_mm_q;
  logic [RPM_W-1:0]   rpm_limit_q;
  logic [GEAR_W-1:0]  gear_ratio_q;
  logic [CIRC_W-1:0]  circ_q;
  ssw_cfg_t           cfg;
  logic               accept;

  ssw_ctl_t           ctl_c   [Q_W+1];
  logic [DivW-1:0]    div_c   [Q_W+1];
  logic [DivW-1:0]    rem_r_c [Q_W+1];
  logic [DivW-1:0]    rem_l_c [Q_W+1];
  logic [Q_W-1:0]     low_r_c [Q_W+1];
  logic [Q_W-1:0]     low_l_c [Q_W+1];
  logic [Q_W-1:0]     quo_r_c [Q_W+1];
  logic [Q_W-1:0]     quo_l_c [Q_W+1];
  logic [NUM_W-1:0]   num_r, num_l;

  logic               done_q;
  logic [OUT_W-1:0]   right_q, left_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      safe_mode_q     <= 1'b0;
      safe_scale_q    <= 11'd614;
      linear_limit_q  <= 15'd512;
      angular_limit_q <= 15'd512;
      track_mm_q      <= 12'd500;
      rpm_limit_q     <= 15'd2600;
      gear_ratio_q    <= 10'd70;
      circ_q          <= 13'd1000;
    end else if (cfg_we_i) begin
      unique case (ssw_reg_e'(cfg_idx_i))
        REG_SAFE_MODE:        safe_mode_q     <= cfg_wdata_i[0];
        REG_SAFE_SCALE:       safe_scale_q    <= cfg_wdata_i[SCALE_W-1:0];
        REG_LINEAR_LIMIT:     linear_limit_q  <= cfg_wdata_i[LIM_W-1:0];
        REG_ANGULAR_LIMIT:    angular_limit_q <= cfg_wdata_i[LIM_W-1:0];
        REG_TRACK_MM:         track_mm_q      <= cfg_wdata_i[TRACK_W-1:0];
        REG_MOTOR_RPM_LIMIT:  rpm_limit_q     <= cfg_wdata_i[RPM_W-1:0];
        REG_GEAR_RATIO:       gear_ratio_q    <= cfg_wdata_i[GEAR_W-1:0];
        REG_CIRCUMFERENCE_MM: circ_q          <= cfg_wdata_i[CIRC_W-1:0];
      endcase
    end
  end

  // Cap the scale at one and treat zero factors as one
  always_comb begin
    cfg.safe_mode        = safe_mode_q;
    cfg.safe_scale       = (safe_scale_q > SCALE_ONE) ? SCALE_ONE : safe_scale_q;
    cfg.linear_limit     = linear_limit_q;
    cfg.angular_limit    = angular_limit_q;
    cfg.track_mm         = track_mm_q;
    cfg.rpm_limit        = (rpm_limit_q == '0) ? RPM_W'(1) : rpm_limit_q;
    cfg.gear_ratio       = (gear_ratio_q == '0) ? GEAR_W'(1) : gear_ratio_q;
    cfg.circumference_mm = (circ_q == '0) ? CIRC_W'(1) : circ_q;
  end

  ssw_kin #(
    .FRAC_BITS (FRAC_BITS)
  ) u_kin (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .start_i        (accept),
    .linear_speed_i (linear_speed_i),
    .yaw_rate_i     (yaw_rate_i),
    .ctl_o          (ctl_c[0]),
    .div_o          (div_c[0]),
    .num_r_o        (num_r),
    .num_l_o        (num_l)
  );

  // Split the dividend into the starting remainder and the bits still to come
  assign rem_r_c[0] = DivW'(num_r[NUM_W-1:Q_W]);
  assign rem_l_c[0] = DivW'(num_l[NUM_W-1:Q_W]);
  assign low_r_c[0] = num_r[Q_W-1:0];
  assign low_l_c[0] = num_l[Q_W-1:0];
  assign quo_r_c[0] = '0;
  assign quo_l_c[0] = '0;

  // Divider chain, one quotient bit per cell
  for (genvar i = 0; i < Q_W; i++) begin : g_div
    ssw_div_cell #(
      .DivW (DivW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl_c[i]),
      .div_i   (div_c[i]),
      .rem_r_i (rem_r_c[i]),
      .rem_l_i (rem_l_c[i]),
      .low_r_i (low_r_c[i]),
      .low_l_i (low_l_c[i]),
      .quo_r_i (quo_r_c[i]),
      .quo_l_i (quo_l_c[i]),
      .ctl_o   (ctl_c[i+1]),
      .div_o   (div_c[i+1]),
      .rem_r_o (rem_r_c[i+1]),
      .rem_l_o (rem_l_c[i+1]),
      .low_r_o (low_r_c[i+1]),
      .low_l_o (low_l_c[i+1]),
      .quo_r_o (quo_r_c[i+1]),
      .quo_l_o (quo_l_c[i+1])
    );
  end

  // Strobe the item out
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctl_c[Q_W].valid;
    end
  end

  // Restore the sign of each quotient
  always_ff @(posedge clk_i) begin
    right_q <= ctl_c[Q_W].neg_r ? -OUT_W'(quo_r_c[Q_W]) : OUT_W'(quo_r_c[Q_W]);
    left_q  <= ctl_c[Q_W].neg_l ? -OUT_W'(quo_l_c[Q_W]) : OUT_W'(quo_l_c[Q_W]);
  end

  assign done_o            = done_q;
  assign right_motor_rpm_o = $signed(right_q);
  assign left_motor_rpm_o  = $signed(left_q);

  // Every result traces back to an item accepted a fixed time earlier
  a_done_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, LATENCY))
    else $error("result without matching accepted item");

endmodule

@@ hw/rtl/ssw_div_cell.sv @@
// One restoring division cell: produces one quotient bit for both wheels.
module ssw_div_cell #(
  parameter int DivW = ssw_pkg::MAG_W
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ssw_pkg::ssw_ctl_t         ctl_i,
  input  logic [DivW-1:0]           div_i,
  input  logic [DivW-1:0]           rem_r_i,
  input  logic [DivW-1:0]           rem_l_i,
  input  logic [ssw_pkg::Q_W-1:0]   low_r_i,
  input  logic [ssw_pkg::Q_W-1:0]   low_l_i,
  input  logic [ssw_pkg::Q_W-1:0]   quo_r_i,
  input  logic [ssw_pkg::Q_W-1:0]   quo_l_i,
  output ssw_pkg::ssw_ctl_t         ctl_o,
  output logic [DivW-1:0]           div_o,
  output logic [DivW-1:0]           rem_r_o,
  output logic [DivW-1:0]           rem_l_o,
  output logic [ssw_pkg::Q_W-1:0]   low_r_o,
  output logic [ssw_pkg::Q_W-1:0]   low_l_o,
  output logic [ssw_pkg::Q_W-1:0]   quo_r_o,
  output logic [ssw_pkg::Q_W-1:0]   quo_l_o
);
  import ssw_pkg::*;

  logic [DivW:0]   shift_r, shift_l;
  logic [DivW:0]   trial_r, trial_l;
  logic            take_r, take_l;
  ssw_ctl_t        ctl_q;
  logic [DivW-1:0] div_q, rem_r_q, rem_l_q;
  logic [Q_W-1:0]  low_r_q, low_l_q, quo_r_q, quo_l_q;

  // Bring down the next dividend bit and try a subtract
  always_comb begin
    shift_r = {rem_r_i, low_r_i[Q_W-1]};
    shift_l = {rem_l_i, low_l_i[Q_W-1]};
    trial_r = shift_r - {1'b0, div_i};
    trial_l = shift_l - {1'b0, div_i};
    take_r  = shift_r >= {1'b0, div_i};
    take_l  = shift_l >= {1'b0, div_i};
  end

  // Hold item control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  // Advance remainder, dividend and quotient
  always_ff @(posedge clk_i) begin
    div_q   <= div_i;
    rem_r_q <= take_r ? trial_r[DivW-1:0] : shift_r[DivW-1:0];
    rem_l_q <= take_l ? trial_l[DivW-1:0] : shift_l[DivW-1:0];
    low_r_q <= {low_r_i[Q_W-2:0], 1'b0};
    low_l_q <= {low_l_i[Q_W-2:0], 1'b0};
    quo_r_q <= {quo_r_i[Q_W-2:0], take_r};
    quo_l_q <= {quo_l_i[Q_W-2:0], take_l};
  end

  assign ctl_o   = ctl_q;
  assign div_o   = div_q;
  assign rem_r_o = rem_r_q;
  assign rem_l_o = rem_l_q;
  assign low_r_o = low_r_q;
  assign low_l_o = low_l_q;
  assign quo_r_o = quo_r_q;
  assign quo_l_o = quo_l_q;

  // Partial remainders stay below the divisor
  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_q.valid |-> (rem_r_q < div_q) && (rem_l_q < div_q))
    else $error("division remainder not below divisor");

endmodule

@@ hw/rtl/ssw_kin.sv @@
// Front pipeline: command shaping, wheel speeds, limit decision and dividend.
module ssw_kin #(
  parameter int FRAC_BITS = ssw_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ssw_pkg::ssw_cfg_t                   cfg_i,
  input  logic                                start_i,
  input  logic signed [ssw_pkg::IN_W-1:0]     linear_speed_i,
  input  logic signed [ssw_pkg::IN_W-1:0]     yaw_rate_i,
  output ssw_pkg::ssw_ctl_t                   ctl_o,
  output logic [ssw_pkg::max_int(ssw_pkg::MAG_W,
                 ssw_pkg::CIRC_W + FRAC_BITS)-1:0] div_o,
  output logic [ssw_pkg::NUM_W-1:0]           num_r_o,
  output logic [ssw_pkg::NUM_W-1:0]           num_l_o
);
  import ssw_pkg::*;

  localparam int DivW = max_int(MAG_W, CIRC_W + FRAC_BITS);
  localparam int CmpW = max_int(NUM_W, CL_W + FRAC_BITS);

  // Divide the safe-factor product by one toward zero, then clamp
  function automatic logic signed [IN_W-1:0] shape(logic signed [PV_W-1:0] pv,
                                                   logic [LIM_W-1:0] lim);
    logic signed [PV_W-1:0]             t;
    logic signed [PV_W-SCALE_SHIFT-1:0] q;
    logic signed [PV_W-SCALE_SHIFT-1:0] l;
    t = pv + (pv[PV_W-1] ? PV_W'(SCALE_ONE - 1'b1) : PV_W'(0));
    q = t[PV_W-1:SCALE_SHIFT];
    l = $signed((PV_W-SCALE_SHIFT)'(lim));
    if (q > l) begin
      return IN_W'(l);
    end else if (q < -l) begin
      return IN_W'(-l);
    end
    return IN_W'(q);
  endfunction

  function automatic logic [MAG_W-1:0] magn(logic signed [WHEEL_W-1:0] v);
    return MAG_W'(v[WHEEL_W-1] ? -v : v);
  endfunction

  logic [SCALE_W-1:0]        scale_eff;
  logic [K_W-1:0]            g30;
  logic [MAG_W-1:0]          magr_c, magl_c;
  logic                      limited_c;

  logic [KIN_STAGES-1:0]     vld_q;
  logic signed [PV_W-1:0]    pvx_q, pw_q;
  logic signed [IN_W-1:0]    vx_q, w_q;
  logic signed [P_W-1:0]     p_q;
  logic signed [TURN_W-1:0]  turn_q;
  logic signed [WHEEL_W-1:0] r_q, l_q;
  logic [MAG_W-1:0]          magr5_q, magl5_q, mx5_q;
  logic                      negr5_q, negl5_q;
  logic [CL_W-1:0]           cl5_q;
  logic [RPM_W-1:0]          lim5_q;
  logic [CIRC_W-1:0]         circ5_q;
  logic [K_W-1:0]            g30_5_q;
  logic [MAG_W-1:0]          magr6_q, magl6_q, mx6_q;
  logic                      negr6_q, negl6_q;
  logic [NUM_W-1:0]          pa6_q;
  logic [CL_W-1:0]           cl6_q;
  logic [RPM_W-1:0]          lim6_q;
  logic [CIRC_W-1:0]         circ6_q;
  logic [K_W-1:0]            g30_6_q;
  logic [MAG_W-1:0]          magr7_q, magl7_q;
  logic                      negr7_q, negl7_q;
  logic [K_W-1:0]            k7_q;
  logic [DivW-1:0]           div7_q;
  logic                      negr8_q, negl8_q;
  logic [DivW-1:0]           div8_q;
  logic [NUM_W-1:0]          numr8_q, numl8_q;

  // Pick the command scale and the gear factor times thirty; wheel magnitudes and limit decision
  always_comb begin
    scale_eff = cfg_i.safe_mode ? cfg_i.safe_scale : SCALE_ONE;
    g30       = (K_W'(cfg_i.gear_ratio) << 5) - (K_W'(cfg_i.gear_ratio) << 1);
    magr_c    = magn(r_q);
    magl_c    = magn(l_q);
    limited_c = CmpW'(pa6_q) > (CmpW'(cl6_q) << FRAC_BITS);
  end

  // Advance item valid through the front stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[KIN_STAGES-2:0], start_i};
    end
  end

  // Datapath stages
  always_ff @(posedge clk_i) begin
    // scale
    pvx_q   <= PV_W'(linear_speed_i) * PV_W'($signed({1'b0, scale_eff}));
    pw_q    <= PV_W'(yaw_rate_i) * PV_W'($signed({1'b0, scale_eff}));
    // shape and clamp
    vx_q    <= shape(pvx_q, cfg_i.linear_limit);
    w_q     <= shape(pw_q, cfg_i.angular_limit);
    // forward and turn terms
    p_q     <= P_W'(vx_q) * P_W'(TRACK_DIV);
    turn_q  <= TURN_W'(w_q) * $signed(TURN_W'(cfg_i.track_mm));
    // wheel speeds
    r_q     <= WHEEL_W'(p_q) - WHEEL_W'(turn_q);
    l_q     <= WHEEL_W'(p_q) + WHEEL_W'(turn_q);
    // magnitudes, larger wheel, config snapshot
    magr5_q <= magr_c;
    magl5_q <= magl_c;
    mx5_q   <= (magr_c > magl_c) ? magr_c : magl_c;
    negr5_q <= r_q[WHEEL_W-1];
    negl5_q <= l_q[WHEEL_W-1];
    cl5_q   <= CL_W'(cfg_i.circumference_mm) * CL_W'(cfg_i.rpm_limit);
    lim5_q  <= cfg_i.rpm_limit;
    circ5_q <= cfg_i.circumference_mm;
    g30_5_q <= g30;
    // larger wheel times gear factor
    magr6_q <= magr5_q;
    magl6_q <= magl5_q;
    mx6_q   <= mx5_q;
    negr6_q <= negr5_q;
    negl6_q <= negl5_q;
    pa6_q   <= NUM_W'(mx5_q) * NUM_W'(g30_5_q);
    cl6_q   <= cl5_q;
    lim6_q  <= lim5_q;
    circ6_q <= circ5_q;
    g30_6_q <= g30_5_q;
    // choose factor and divisor
    magr7_q <= magr6_q;
    magl7_q <= magl6_q;
    negr7_q <= negr6_q;
    negl7_q <= negl6_q;
    k7_q    <= limited_c ? K_W'(lim6_q) : g30_6_q;
    div7_q  <= limited_c ? DivW'(mx6_q) : (DivW'(circ6_q) << FRAC_BITS);
    // dividends
    negr8_q <= negr7_q;
    negl8_q <= negl7_q;
    div8_q  <= div7_q;
    numr8_q <= NUM_W'(magr7_q) * NUM_W'(k7_q);
    numl8_q <= NUM_W'(magl7_q) * NUM_W'(k7_q);
  end

  assign ctl_o   = '{valid: vld_q[KIN_STAGES-1], neg_r: negr8_q, neg_l: negl8_q};
  assign div_o   = div8_q;
  assign num_r_o = numr8_q;
  assign num_l_o = numl8_q;

  // Larger wheel covers both magnitudes
  a_max_covers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[4] |-> (mx5_q >= magr5_q) && (mx5_q >= magl5_q))
    else $error("larger wheel magnitude below a wheel magnitude");

  // Divisor never zero for a live item
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[6] |-> (div7_q != '0))
    else $error("zero divisor");

endmodule

@@ verif/tb_top.sv @@
// Testbench for skid_steer_wheel_rpm: queued velocity commands, predicted wheel rpm, checks.
`timescale 1ns / 100ps

module tb_top;
  import ssw_pkg::*;

  localparam int FRAC_BITS  = FRAC_BITS_DEF;
  localparam int CLK_PERIOD = 10;
  localparam int LATENCY    = 24;
  localparam int QUIET_MAX  = 2000;
  localparam int PHASES     = 10;
  localparam int PHASE_LEN  = 150;

  typedef struct packed {
    logic signed [IN_W-1:0] lin;
    logic signed [IN_W-1:0] yaw;
  } vel_cmd_t;

  typedef struct packed {
    logic [OUT_W-1:0] right;
    logic [OUT_W-1:0] left;
  } rpm_pair_t;

  logic                    clk_i          = 1'b0;
  logic                    rst_ni         = 1'b0;
  logic                    start          = 1'b0;
  logic                    busy;
  logic signed [IN_W-1:0]  linear_speed_i = '0;
  logic signed [IN_W-1:0]  yaw_rate_i     = '0;
  logic                    cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_idx_i      = '0;
  logic [CFG_W-1:0]        cfg_wdata_i    = '0;
  logic                    done_o;
  logic signed [OUT_W-1:0] right_motor_rpm_o;
  logic signed [OUT_W-1:0] left_motor_rpm_o;

  // Mirror of the block's registers and the traffic in flight
  ssw_cfg_t  cfg;
  vel_cmd_t  cmd_queue[$];
  rpm_pair_t rpm_due[$];
  int        idle_pct = 0;
  int        errors   = 0;
  int        quiet    = 0;

  skid_steer_wheel_rpm #(
    .FRAC_BITS(FRAC_BITS)
  ) DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .linear_speed_i    (linear_speed_i),
    .yaw_rate_i        (yaw_rate_i),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .done_o            (done_o),
    .right_motor_rpm_o (right_motor_rpm_o),
    .left_motor_rpm_o  (left_motor_rpm_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic longint mag64(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Safe-mode scaling, then clamp to +-limit
  function automatic longint shape_cmd(longint v, longint limit);
    longint s;
    if (cfg.safe_mode) begin
      s = (cfg.safe_scale > SCALE_ONE) ? longint'(SCALE_ONE) : longint'(cfg.safe_scale);
      v = (v * s) / longint'(SCALE_ONE);
    end
    if (v > limit) v = limit;
    else if (v < -limit) v = -limit;
    return v;
  endfunction

  // Motor rpm of both wheels for one velocity command
  function automatic rpm_pair_t wheel_rpm_of(logic signed [IN_W-1:0] lin,
                                             logic signed [IN_W-1:0] yaw);
    longint    vx, w, turn, r, l, gear, circ, lim, one, mx, rr, lr;
    rpm_pair_t p;
    vx   = shape_cmd(longint'(lin), longint'(cfg.linear_limit));
    w    = shape_cmd(longint'(yaw), longint'(cfg.angular_limit));
    turn = longint'(cfg.track_mm) * w;
    r    = longint'(TRACK_DIV) * vx - turn;
    l    = longint'(TRACK_DIV) * vx + turn;
    gear = (cfg.gear_ratio == 0) ? 64'sd1 : longint'(cfg.gear_ratio);
    circ = (cfg.circumference_mm == 0) ? 64'sd1 : longint'(cfg.circumference_mm);
    lim  = (cfg.rpm_limit == 0) ? 64'sd1 : longint'(cfg.rpm_limit);
    one  = longint'(1) << FRAC_BITS;
    mx   = (mag64(r) > mag64(l)) ? mag64(r) : mag64(l);
    // Scale both wheels by the same ratio when the faster one is over the limit
    if (mx * 30 * gear > circ * lim * one) begin
      rr = (r * lim) / mx;
      lr = (l * lim) / mx;
    end else begin
      rr = (r * 30 * gear) / (circ * one);
      lr = (l * 30 * gear) / (circ * one);
    end
    p.right = OUT_W'(rr);
    p.left  = OUT_W'(lr);
    return p;
  endfunction

  // Random command: full range, near the limits, extremes, or small values
  function automatic vel_cmd_t rand_cmd();
    vel_cmd_t c;
    int       ll, al;
    int       edges[5] = '{-32768, 32767, 0, -1, 1};
    ll = 2 * int'(cfg.linear_limit) + 4;
    al = 2 * int'(cfg.angular_limit) + 4;
    case ($urandom_range(3))
      0: begin
        c.lin = IN_W'($urandom);
        c.yaw = IN_W'($urandom);
      end
      1: begin
        c.lin = IN_W'(int'($urandom_range(2 * ll)) - ll);
        c.yaw = IN_W'(int'($urandom_range(2 * al)) - al);
      end
      2: begin
        c.lin = IN_W'(edges[$urandom_range(4)]);
        c.yaw = IN_W'(edges[$urandom_range(4)]);
      end
      default: begin
        c.lin = IN_W'(int'($urandom_range(2047)) - 1024);
        c.yaw = IN_W'(int'($urandom_range(2047)) - 1024);
      end
    endcase
    return c;
  endfunction

  function automatic ssw_cfg_t rand_setting();
    ssw_cfg_t s;
    s.safe_mode        = 1'($urandom_range(1));
    s.safe_scale       = ($urandom_range(3) == 0) ? SCALE_W'($urandom_range(2047))
                                                  : SCALE_W'($urandom_range(1024));
    s.linear_limit     = $urandom_range(1) ? LIM_W'($urandom_range(2047))
                                           : LIM_W'($urandom_range(32767));
    s.angular_limit    = $urandom_range(1) ? LIM_W'($urandom_range(2047))
                                           : LIM_W'($urandom_range(32767));
    s.track_mm         = TRACK_W'($urandom_range(4095, 1));
    s.rpm_limit        = RPM_W'($urandom_range(20000, 1));
    s.gear_ratio       = GEAR_W'($urandom_range(1000, 1));
    s.circumference_mm = CIRC_W'($urandom_range(8191, 1));
    return s;
  endfunction

  // Drive one register write and update the mirror
  task automatic write_reg(ssw_reg_e idx, logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      REG_SAFE_MODE:        cfg.safe_mode        = val[0];
      REG_SAFE_SCALE:       cfg.safe_scale       = SCALE_W'(val);
      REG_LINEAR_LIMIT:     cfg.linear_limit     = LIM_W'(val);
      REG_ANGULAR_LIMIT:    cfg.angular_limit    = LIM_W'(val);
      REG_TRACK_MM:         cfg.track_mm         = TRACK_W'(val);
      REG_MOTOR_RPM_LIMIT:  cfg.rpm_limit        = RPM_W'(val);
      REG_GEAR_RATIO:       cfg.gear_ratio       = GEAR_W'(val);
      REG_CIRCUMFERENCE_MM: cfg.circumference_mm = CIRC_W'(val);
      default: ;
    endcase
  endtask

  task automatic apply_setting(ssw_cfg_t s);
    write_reg(REG_SAFE_MODE,        CFG_W'(s.safe_mode));
    write_reg(REG_SAFE_SCALE,       CFG_W'(s.safe_scale));
    write_reg(REG_LINEAR_LIMIT,     CFG_W'(s.linear_limit));
    write_reg(REG_ANGULAR_LIMIT,    CFG_W'(s.angular_limit));
    write_reg(REG_TRACK_MM,         CFG_W'(s.track_mm));
    write_reg(REG_MOTOR_RPM_LIMIT,  CFG_W'(s.rpm_limit));
    write_reg(REG_GEAR_RATIO,       CFG_W'(s.gear_ratio));
    write_reg(REG_CIRCUMFERENCE_MM, CFG_W'(s.circumference_mm));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Hold until every queued item is accepted and every result has come back
  task automatic wait_drained();
    do @(negedge clk_i);
    while (cmd_queue.size() != 0 || start || rpm_due.size() != 0);
  endtask

  task automatic push_cmd(int lin, int yaw);
    vel_cmd_t c;
    c.lin = IN_W'(lin);
    c.yaw = IN_W'(yaw);
    cmd_queue.insert(cmd_queue.size(), c);
  endtask

  // Driver: predict on acceptance, then present the next item or idle
  always @(posedge clk_i) begin : drive_items
    vel_cmd_t nxt;
    if (start && !busy) rpm_due.insert(rpm_due.size(), wheel_rpm_of(linear_speed_i, yaw_rate_i));
    if (rst_ni && (!start || !busy)) begin
      if (cmd_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
        nxt            = cmd_queue.pop_front();
        start          <= 1'b1;
        linear_speed_i <= nxt.lin;
        yaw_rate_i     <= nxt.yaw;
      end else begin
        start          <= 1'b0;
        linear_speed_i <= IN_W'($urandom);
        yaw_rate_i     <= IN_W'($urandom);
      end
    end
  end

  // Monitor: compare each result with the oldest prediction
  always @(posedge clk_i) begin : check_results
    rpm_pair_t want;
    if (rst_ni && done_o) begin
      if (rpm_due.size() == 0) begin
        $error("result with nothing pending: right %0d left %0d",
               right_motor_rpm_o, left_motor_rpm_o);
        errors++;
      end else begin
        want = rpm_due.pop_front();
        if (right_motor_rpm_o !== want.right) begin
          $error("right_motor_rpm expected %0d actual %0d",
                 $signed(want.right), right_motor_rpm_o);
          errors++;
        end
        if (left_motor_rpm_o !== want.left) begin
          $error("left_motor_rpm expected %0d actual %0d",
                 $signed(want.left), left_motor_rpm_o);
          errors++;
        end
      end
    end
  end

  // Watchdog: drop the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= QUIET_MAX) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin : run
    ssw_cfg_t s;
    int       pattern[4] = '{0, 64, 0, 33};
    cfg.safe_mode        = 1'b0;
    cfg.safe_scale       = 11'd614;
    cfg.linear_limit     = 15'd512;
    cfg.angular_limit    = 15'd512;
    cfg.track_mm         = 12'd500;
    cfg.rpm_limit        = 15'd2600;
    cfg.gear_ratio       = 10'd70;
    cfg.circumference_mm = 13'd1000;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed items under reset values: extremes, clamp edges, limiting on and off
    push_cmd(0, 0);
    push_cmd(32767, 32767);
    push_cmd(-32768, -32768);
    push_cmd(32767, -32768);
    push_cmd(-32768, 32767);
    push_cmd(512, 0);
    push_cmd(513, 0);
    push_cmd(-513, 0);
    push_cmd(0, 512);
    push_cmd(0, -513);
    push_cmd(1, -1);
    push_cmd(-1, 1);
    push_cmd(300, 100);
    push_cmd(-300, 100);
    push_cmd(512, 512);
    wait_drained();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        // Largest values everywhere, scale above one
        0: s = '{safe_mode: 1'b1, safe_scale: 11'd2047, linear_limit: 15'd32767,
                 angular_limit: 15'd32767, track_mm: 12'd4095, rpm_limit: 15'd32767,
                 gear_ratio: 10'd1023, circumference_mm: 13'd8191};
        // Zero scale, zero limits and zero parameters
        1: s = '{safe_mode: 1'b1, safe_scale: 11'd0, linear_limit: 15'd0,
                 angular_limit: 15'd0, track_mm: 12'd0, rpm_limit: 15'd0,
                 gear_ratio: 10'd0, circumference_mm: 13'd0};
        // Small wheel, high gearing: limiting most of the time
        2: s = '{safe_mode: 1'b0, safe_scale: 11'd1024, linear_limit: 15'd32767,
                 angular_limit: 15'd32767, track_mm: 12'd4095, rpm_limit: 15'd20000,
                 gear_ratio: 10'd1000, circumference_mm: 13'd1};
        // Unit scale, minimal parameters
        3: s = '{safe_mode: 1'b1, safe_scale: 11'd1024, linear_limit: 15'd1,
                 angular_limit: 15'd1, track_mm: 12'd1, rpm_limit: 15'd1,
                 gear_ratio: 10'd1, circumference_mm: 13'd1};
        default: s = rand_setting();
      endcase
      apply_setting(s);
      idle_pct = pattern[ph % 4];
      for (int i = 0; i < PHASE_LEN; i++) cmd_queue.insert(cmd_queue.size(), rand_cmd());
      wait_drained();
    end

    // Let the pipeline run out before the verdict
    repeat (LATENCY + 8) @(posedge clk_i);
    if (rpm_due.size() != 0) begin
      $error("%0d results never arrived", rpm_due.size());
      errors++;
    end
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ skid_steer_wheel_rpm.f @@
hw/rtl/ssw_pkg.sv
hw/rtl/ssw_div_cell.sv
hw/rtl/ssw_kin.sv
hw/rtl/skid_steer_wheel_rpm.sv
verif/tb_top.sv
